// ===== rtl/core/arpc_pkg.sv =====
// Package for the ARP cache and responder core: item types, status codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

    typedef enum logic [1:0] {
        KIND_PACKET = 2'd0,
        KIND_SWEEP  = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_HW    = 3'd2,
        ST_BAD_PROTO = 3'd3,
        ST_BAD_LEN   = 3'd4,
        ST_NOT_US    = 3'd5
    } status_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE, B_READ, B_CHECK, B_SWAP_RD, B_SWAP_WR, B_DONE
    } bstate_t;

    // Register indexes of the write port
    localparam logic [1:0] REG_OWN_IP   = 2'd0;
    localparam logic [1:0] REG_OWN_MAC  = 2'd1;
    localparam logic [1:0] REG_LIFETIME = 2'd2;

    localparam logic [15:0] MIN_FRAME_LEN = 16'd28;
    localparam logic [15:0] HW_ETHERNET   = 16'h0001;
    localparam logic [15:0] PROTO_IPV4    = 16'h0800;
    localparam logic [7:0]  HW_LEN        = 8'd6;
    localparam logic [7:0]  IPV4_ADDR_LEN = 8'd4;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [31:0] LIFETIME_RST  = 32'd1000;

    // Classified item handed from the front to the back
    typedef struct packed {
        kind_t       kind;
        status_t     status;   // check result for packets
        logic        request;
        logic [63:0] now;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] query_ip;
    } job_t;

    typedef struct packed {
        status_t     status;
        logic        entry_added;
        logic        reply_send;
        logic [47:0] reply_dest_mac;
        logic [31:0] reply_dest_ip;
        logic        lookup_hit;
        logic [47:0] lookup_mac;
        logic [5:0]  expired_count;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/arp_cache_responder_core.sv =====
// Top level of the ARP cache and responder: config registers, front, queue, back.
// Depends on arpc_pkg, arpc_front, arpc_queue, arpc_back.
//
//   channel | dir | handshake         | payload
//   s_      | in  | s_tvalid/s_tready | s_tuser: kind; s_tdata: the other item fields
//   m_      | out | m_tvalid/m_tready | m_tdata: one result per item
//   cfg     | in  | cfg_wr_en         | cfg_index, cfg_data
//
// The back handles one item at a time, scanning the single-port table entry by
// entry; a sweep moves the last entry into each slot it frees. It takes no new
// item until its result is taken. Reset is synchronous, active low, and empties
// the table at once. A stalled result holds the back; the two-entry queue
// keeps accepting items meanwhile until it is full.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_responder_core
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
)(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // kind
    input  wire logic [1:0]   s_tuser,
    // now, frame_length, hw_type, protocol type, hw_addr_len, proto_addr_len,
    // operation, sender_mac, sender_ip, target_ip, query_ip (from bit 0 up)
    input  wire logic [287:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, entry_added, reply_send, reply_dest_mac, reply_dest_ip,
    // lookup_hit, lookup_mac, expired_count (from bit 0 up)
    output logic [143:0]      m_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [47:0]  cfg_data
);

    logic [31:0] own_ip_reg, lifetime_reg;
    logic [47:0] own_mac_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg   <= '0;
            own_mac_reg  <= '0;
            lifetime_reg <= LIFETIME_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OWN_IP:   own_ip_reg   <= cfg_data[31:0];
                REG_OWN_MAC:  own_mac_reg  <= cfg_data;
                REG_LIFETIME: lifetime_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    job_t    f_job, q_job;
    logic    f_valid, f_ready, q_valid, q_ready;
    result_t res;

    arpc_front u_front (
        .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .own_ip(own_ip_reg), .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
    );

    arpc_queue u_queue (
        .aclk, .aresetn, .in_job(f_job), .in_valid(f_valid), .in_ready(f_ready),
        .out_job(q_job), .out_valid(q_valid), .out_ready(q_ready)
    );

    arpc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .aclk, .aresetn, .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
        .lifetime_ticks(lifetime_reg), .res, .res_valid(m_tvalid), .res_ready(m_tready)
    );

    assign m_tdata = {4'b0000, res.expired_count, res.lookup_mac, res.lookup_hit,
                      res.reply_dest_ip, res.reply_dest_mac, res.reply_send,
                      res.entry_added, res.status};

    logic unused_mac;
    assign unused_mac = ^own_mac_reg;

endmodule
`default_nettype wire

// ===== rtl/core/arpc_front.sv =====
// Front of the ARP core: accepts items, checks header fields, pushes jobs to a queue.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arpc_front
    import arpc_pkg::*;
(
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,
    input  wire logic [287:0] s_tdata,
    input  wire logic [31:0]  own_ip,
    output job_t              job,
    output logic              job_valid,
    input  wire logic         job_ready
);

    logic [15:0] frame_length, hw_type, ptype, operation;
    logic [7:0]  hw_addr_len, proto_addr_len;
    logic [31:0] target_ip;

    assign frame_length   = s_tdata[79:64];
    assign hw_type        = s_tdata[95:80];
    assign ptype          = s_tdata[111:96];
    assign hw_addr_len    = s_tdata[119:112];
    assign proto_addr_len = s_tdata[127:120];
    assign operation      = s_tdata[143:128];
    assign target_ip      = s_tdata[255:224];

    assign s_tready  = job_ready;
    assign job_valid = s_tvalid;

    // header checks in priority order
    always_comb begin
        job.kind       = kind_t'(s_tuser);
        job.now        = s_tdata[63:0];
        job.sender_mac = s_tdata[191:144];
        job.sender_ip  = s_tdata[223:192];
        job.query_ip   = s_tdata[287:256];
        job.request    = (operation == OP_REQUEST);
        if (frame_length < MIN_FRAME_LEN) begin
            job.status = ST_SHORT;
        end else if (hw_type != HW_ETHERNET) begin
            job.status = ST_BAD_HW;
        end else if (ptype != PROTO_IPV4) begin
            job.status = ST_BAD_PROTO;
        end else if (hw_addr_len != HW_LEN || proto_addr_len != IPV4_ADDR_LEN) begin
            job.status = ST_BAD_LEN;
        end else if (target_ip != own_ip) begin
            job.status = ST_NOT_US;
        end else begin
            job.status = ST_OK;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/arpc_queue.sv =====
// Two-entry queue between the front and back of the ARP core.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arpc_queue
    import arpc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire job_t in_job,
    input  wire logic in_valid,
    output logic      in_ready,
    output job_t      out_job,
    output logic      out_valid,
    input  wire logic out_ready
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push, pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_job   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // payload slots
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_job;
    end

endmodule
`default_nettype wire

// ===== rtl/core/arpc_back.sv =====
// Back of the ARP core: table sequencer that scans entries one at a time and finishes each item before taking the next.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arpc_back
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
)(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire job_t        job,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  wire logic [31:0] lifetime_ticks,
    output result_t          res,
    output logic             res_valid,
    input  wire logic        res_ready
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [31:0] ip_mem [TABLE_ENTRIES];
    logic [47:0] mac_mem [TABLE_ENTRIES];
    logic [63:0] dl_mem [TABLE_ENTRIES];

    bstate_t     state_reg, state_next;
    job_t        job_reg, job_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic        found_reg, found_next;
    logic [5:0]  exp_reg, exp_next;
    logic [63:0] deadline_reg, deadline_next;
    result_t     res_reg, res_next;
    logic        rvalid_reg, rvalid_next;

    logic [31:0] rd_ip_reg;
    logic [47:0] rd_mac_reg;
    logic [63:0] rd_dl_reg;
    logic [IW-1:0] rd_addr;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0] wr_ip;
    logic [47:0] wr_mac;
    logic [63:0] wr_dl;
    logic [31:0] key_ip;
    logic        valid_pkt;

    assign job_ready = (state_reg == B_IDLE) && !rvalid_reg;
    assign res       = res_reg;
    assign res_valid = rvalid_reg;
    assign key_ip    = (job_reg.kind == KIND_LOOKUP) ? job_reg.query_ip : job_reg.sender_ip;
    assign valid_pkt = (job_reg.status == ST_OK) || (job_reg.status == ST_NOT_US);

    // table memories, one port each way
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ip_mem[wr_addr]  <= wr_ip;
            mac_mem[wr_addr] <= wr_mac;
            dl_mem[wr_addr]  <= wr_dl;
        end
        rd_ip_reg  <= ip_mem[rd_addr];
        rd_mac_reg <= mac_mem[rd_addr];
        rd_dl_reg  <= dl_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= B_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
        end
        job_reg      <= job_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        exp_reg      <= exp_next;
        deadline_reg <= deadline_next;
        res_reg      <= res_next;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        exp_next      = exp_reg;
        deadline_next = deadline_reg;
        res_next      = res_reg;
        rvalid_next   = rvalid_reg;
        rd_addr       = idx_reg[IW-1:0];
        wr_en         = 1'b0;
        wr_addr       = idx_reg[IW-1:0];
        wr_ip         = rd_ip_reg;
        wr_mac        = rd_mac_reg;
        wr_dl         = rd_dl_reg;
        if (rvalid_reg && res_ready) rvalid_next = 1'b0;

        unique case (state_reg)
            B_IDLE: begin
                if (job_valid && job_ready) begin
                    job_next      = job;
                    idx_next      = '0;
                    found_next    = 1'b0;
                    exp_next      = '0;
                    deadline_next = job.now + {32'd0, lifetime_ticks};
                    state_next    = B_READ;
                end
            end
            B_READ: begin
                // issue read of idx, or finish when scan is over
                if (job_reg.kind == KIND_NONE ||
                    (job_reg.kind == KIND_PACKET && !valid_pkt) ||
                    idx_reg >= count_reg || found_reg) begin
                    state_next = B_DONE;
                end else begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK: begin
                if (job_reg.kind == KIND_SWEEP) begin
                    if (rd_dl_reg < job_reg.now) begin
                        count_next = count_reg - CW'(1);
                        exp_next   = exp_reg + 6'd1;
                        rd_addr    = count_next[IW-1:0];
                        state_next = B_SWAP_RD;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = B_READ;
                    end
                end else if (rd_ip_reg == key_ip) begin
                    found_next = 1'b1;
                    if (job_reg.kind == KIND_PACKET) begin
                        wr_en  = 1'b1;
                        wr_ip  = rd_ip_reg;
                        wr_mac = job_reg.sender_mac;
                        wr_dl  = deadline_reg;
                    end
                    res_next.lookup_mac = rd_mac_reg;
                    state_next = B_DONE;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = B_READ;
                end
            end
            B_SWAP_RD: begin
                rd_addr    = count_reg[IW-1:0];
                state_next = B_SWAP_WR;
            end
            B_SWAP_WR: begin
                // last entry moves into the freed slot, then is checked
                wr_en      = 1'b1;
                state_next = B_READ;
            end
            B_DONE: begin
                if (!rvalid_reg || res_ready) begin
                    res_next = '0;
                    res_next.status = ST_OK;
                    state_next = B_IDLE;
                    rvalid_next = 1'b1;
                    case (job_reg.kind)
                        KIND_PACKET: begin
                            res_next.status = job_reg.status;
                            if (job_reg.status == ST_OK) begin
                                if (!found_reg && count_reg < CW'(TABLE_ENTRIES)) begin
                                    wr_en   = 1'b1;
                                    wr_addr = count_reg[IW-1:0];
                                    wr_ip   = job_reg.sender_ip;
                                    wr_mac  = job_reg.sender_mac;
                                    wr_dl   = deadline_reg;
                                    count_next = count_reg + CW'(1);
                                    res_next.entry_added = 1'b1;
                                end
                                if (job_reg.request) begin
                                    res_next.reply_send     = 1'b1;
                                    res_next.reply_dest_mac = job_reg.sender_mac;
                                    res_next.reply_dest_ip  = job_reg.sender_ip;
                                end
                            end
                        end
                        KIND_SWEEP: res_next.expired_count = exp_reg;
                        KIND_LOOKUP: begin
                            res_next.lookup_hit = found_reg;
                            res_next.lookup_mac = found_reg ? res_reg.lookup_mac : 48'd0;
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== verif/arp_cache_responder_core_test.sv =====
// Self-checking testbench for arp_cache_responder_core: ARP header checks, table
// add/refresh, replies, lookups and expiry sweeps against a built-in cache predictor.
// Depends on arpc_pkg and the arp_cache_responder_core RTL.
`timescale 1ns / 1ps
module arp_cache_responder_core_test;
    import arpc_pkg::*;

    localparam int N_ENTRIES = 32;
    localparam int DRAIN_CYCLES = 200;

    localparam logic [15:0] OP_REPLY = 16'h0002;

    // Input item: kind in the lowest bits goes on s_tuser, the rest on s_tdata
    typedef struct packed {
        logic [31:0] query_ip;
        logic [31:0] target_ip;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [15:0] operation;
        logic [7:0]  proto_addr_len;
        logic [7:0]  hw_addr_len;
        logic [15:0] ptype;
        logic [15:0] hw_type;
        logic [15:0] frame_length;
        logic [63:0] now;
        kind_t       kind;
    } arp_item_t;

    // Result as packed on m_tdata
    typedef struct packed {
        logic [3:0]  pad;
        logic [5:0]  expired_count;
        logic [47:0] lookup_mac;
        logic        lookup_hit;
        logic [31:0] reply_dest_ip;
        logic [47:0] reply_dest_mac;
        logic        reply_send;
        logic        entry_added;
        status_t     status;
    } arp_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = REG_OWN_IP;
    logic [47:0]  cfg_data = '0;

    arp_cache_responder_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predicted cache state and registers
    logic [31:0] own_ip_q;
    logic [31:0] lifetime_q;
    int          cache_count;
    logic [31:0] cache_ip  [N_ENTRIES];
    logic [47:0] cache_mac [N_ENTRIES];
    logic [63:0] cache_dl  [N_ENTRIES];

    arp_result_t expected_results[$];
    int          error_count = 0;

    // Sender burst shaping
    int          burst_left = 0;
    logic [63:0] clock_now;
    logic [31:0] ip_pool [48];

    function automatic int find_cached(logic [31:0] ip);
        for (int i = 0; i < cache_count; i++)
            if (cache_ip[i] == ip) return i;
        return -1;
    endfunction

    // Work out the result of one item and update the predicted table
    function automatic arp_result_t predict_arp(arp_item_t it);
        arp_result_t r;
        int          idx;
        int          i;
        logic [63:0] deadline;
        r = '0;
        r.status = ST_OK;
        case (it.kind)
            KIND_PACKET: begin
                if (it.frame_length < MIN_FRAME_LEN) r.status = ST_SHORT;
                else if (it.hw_type != HW_ETHERNET) r.status = ST_BAD_HW;
                else if (it.ptype != PROTO_IPV4) r.status = ST_BAD_PROTO;
                else if (it.hw_addr_len != HW_LEN || it.proto_addr_len != IPV4_ADDR_LEN)
                    r.status = ST_BAD_LEN;
                else begin
                    deadline = it.now + {32'd0, lifetime_q};
                    idx = find_cached(it.sender_ip);
                    if (idx >= 0) begin
                        cache_mac[idx] = it.sender_mac;
                        cache_dl[idx]  = deadline;
                    end
                    if (it.target_ip != own_ip_q) r.status = ST_NOT_US;
                    else begin
                        if (idx < 0 && cache_count < N_ENTRIES) begin
                            cache_ip[cache_count]  = it.sender_ip;
                            cache_mac[cache_count] = it.sender_mac;
                            cache_dl[cache_count]  = deadline;
                            cache_count++;
                            r.entry_added = 1'b1;
                        end
                        if (it.operation == OP_REQUEST) begin
                            r.reply_send     = 1'b1;
                            r.reply_dest_mac = it.sender_mac;
                            r.reply_dest_ip  = it.sender_ip;
                        end
                    end
                end
            end
            KIND_SWEEP: begin
                // removed slot takes the last entry, which is checked next
                i = 0;
                while (i < cache_count) begin
                    if (cache_dl[i] < it.now) begin
                        cache_count--;
                        cache_ip[i]  = cache_ip[cache_count];
                        cache_mac[i] = cache_mac[cache_count];
                        cache_dl[i]  = cache_dl[cache_count];
                        r.expired_count++;
                    end else begin
                        i++;
                    end
                end
            end
            KIND_LOOKUP: begin
                idx = find_cached(it.query_ip);
                if (idx >= 0) begin
                    r.lookup_hit = 1'b1;
                    r.lookup_mac = cache_mac[idx];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one item, with bursts and random gaps; predict on acceptance
    task automatic send_item(arp_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 15);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= it[289:2];
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_arp(it));
    endtask

    // Stop sending and wait for every result before touching registers
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_OWN_IP:   own_ip_q   = val[31:0];
            REG_LIFETIME: lifetime_q = val[31:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic arp_item_t rand_fields();
        arp_item_t it;
        it = '0;
        it.kind           = kind_t'($urandom_range(0, 3));
        it.now            = {$urandom, $urandom};
        it.frame_length   = 16'($urandom);
        it.hw_type        = 16'($urandom);
        it.ptype          = 16'($urandom);
        it.hw_addr_len    = 8'($urandom);
        it.proto_addr_len = 8'($urandom);
        it.operation      = 16'($urandom);
        it.sender_mac     = 48'({$urandom, $urandom});
        it.sender_ip      = $urandom;
        it.target_ip      = $urandom;
        it.query_ip       = $urandom;
        return it;
    endfunction

    function automatic arp_item_t good_packet(logic [31:0] sip, logic [31:0] tip,
                                              logic [15:0] op, logic [63:0] t);
        arp_item_t it;
        it = rand_fields();
        it.kind           = KIND_PACKET;
        it.now            = t;
        it.frame_length   = 16'($urandom_range(28, 65535));
        it.hw_type        = HW_ETHERNET;
        it.ptype          = PROTO_IPV4;
        it.hw_addr_len    = HW_LEN;
        it.proto_addr_len = IPV4_ADDR_LEN;
        it.operation      = op;
        it.sender_ip      = sip;
        it.target_ip      = tip;
        return it;
    endfunction

    function automatic arp_item_t simple_item(kind_t k, logic [63:0] t, logic [31:0] qip);
        arp_item_t it;
        it = rand_fields();
        it.kind     = k;
        it.now      = t;
        it.query_ip = qip;
        return it;
    endfunction

    // Empty table, reset register values, unused kind
    task automatic test_reset_state();
        arp_item_t it;
        send_item(simple_item(KIND_LOOKUP, 64'd0, 32'd0));
        send_item(simple_item(KIND_SWEEP, '1, 32'd0));
        send_item(good_packet(32'h0A00_0001, 32'd0, OP_REQUEST, 64'd0));
        send_item(simple_item(KIND_LOOKUP, 64'd5, 32'h0A00_0001));
        it = rand_fields();
        it.kind = KIND_NONE;
        send_item(it);
        it = '1;
        send_item(it);
        send_item(simple_item(KIND_SWEEP, 64'd1000, 32'd0));
        send_item(simple_item(KIND_SWEEP, 64'd1001, 32'd0));
    endtask

    // Each header check, the short-frame edge and the not-for-us refresh
    task automatic test_header_checks();
        arp_item_t it;
        send_item(good_packet(32'h0A00_0002, 32'd0, OP_REPLY, 64'd10));
        it = good_packet(32'h0A00_0003, 32'd0, OP_REQUEST, 64'd10);
        it.frame_length = 16'd27;
        send_item(it);
        it.frame_length = 16'd0;
        send_item(it);
        it.frame_length = 16'hFFFF;
        it.hw_type = 16'h0000;
        send_item(it);
        it.hw_type = 16'hFFFF;
        send_item(it);
        it.hw_type = HW_ETHERNET;
        it.ptype = 16'h0801;
        send_item(it);
        it.ptype = PROTO_IPV4;
        it.hw_addr_len = 8'hFF;
        send_item(it);
        it.hw_addr_len = HW_LEN;
        it.proto_addr_len = 8'd0;
        send_item(it);
        it.frame_length = MIN_FRAME_LEN;
        it.proto_addr_len = IPV4_ADDR_LEN;
        send_item(it);
        send_item(good_packet(32'h0A00_0002, 32'hFFFF_FFFF, OP_REQUEST, 64'd20));
        send_item(simple_item(KIND_LOOKUP, 64'd0, 32'h0A00_0002));
        send_item(simple_item(KIND_LOOKUP, 64'd0, 32'h0A00_0004));
    endtask

    // Deadline wrapping modulo 2^64 and the equal-deadline survival rule
    task automatic test_deadline_wrap();
        drain_results();
        write_reg(REG_LIFETIME, 48'hFFFF_FFFF);
        write_reg(REG_OWN_MAC, '1);
        send_item(good_packet(32'h0A00_0002, 32'd5, OP_REQUEST, 64'hFFFF_FFFF_FFFF_FFF6));
        send_item(simple_item(KIND_SWEEP, 64'hFFFF_FFF5, 32'd0));
        send_item(simple_item(KIND_SWEEP, 64'hFFFF_FFF6, 32'd0));
        send_item(simple_item(KIND_LOOKUP, 64'd0, 32'h0A00_0002));
    endtask

    // Mostly well-formed traffic on a small address pool so the table fills and ages
    task automatic test_random_traffic(logic [31:0] own_ip, logic [47:0] own_mac,
                                       logic [31:0] lifetime, logic [63:0] start,
                                       int step_max, int n_items);
        arp_item_t it;
        int        pick;
        drain_results();
        write_reg(REG_OWN_IP, 48'(own_ip));
        write_reg(REG_OWN_MAC, own_mac);
        write_reg(REG_LIFETIME, 48'(lifetime));
        clock_now = start;
        repeat (n_items) begin
            clock_now += $urandom_range(0, step_max);
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                it = good_packet(ip_pool[$urandom_range(0, 47)],
                                 ($urandom_range(0, 3) != 0) ? own_ip :
                                     ip_pool[$urandom_range(0, 47)],
                                 ($urandom_range(0, 9) < 7) ? OP_REQUEST : 16'($urandom),
                                 clock_now);
            end else if (pick < 70) begin
                it = simple_item(KIND_SWEEP, clock_now, 32'd0);
            end else if (pick < 86) begin
                it = simple_item(KIND_LOOKUP, clock_now,
                                 ($urandom_range(0, 4) != 0) ? ip_pool[$urandom_range(0, 47)]
                                                             : 32'($urandom));
            end else if (pick < 95) begin
                // broken header, one check failing at a time
                it = good_packet(ip_pool[$urandom_range(0, 47)], own_ip, OP_REQUEST,
                                 clock_now);
                case ($urandom_range(0, 4))
                    0: it.frame_length = 16'($urandom_range(0, 27));
                    1: it.hw_type = 16'h0002 + 16'($urandom_range(0, 65533));
                    2: it.ptype = it.ptype ^ (16'd1 << $urandom_range(0, 15));
                    3: it.hw_addr_len = it.hw_addr_len ^ (8'd1 << $urandom_range(0, 7));
                    default: it.proto_addr_len = it.proto_addr_len ^ (8'd1 << $urandom_range(0, 7));
                endcase
            end else begin
                it = rand_fields();
            end
            send_item(it);
        end
    endtask

    // Result checker
    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        arp_result_t got;
        arp_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("status", exp_r.status, got.status);
                check_field("entry_added", exp_r.entry_added, got.entry_added);
                check_field("reply_send", exp_r.reply_send, got.reply_send);
                check_field("reply_dest_mac", exp_r.reply_dest_mac, got.reply_dest_mac);
                check_field("reply_dest_ip", exp_r.reply_dest_ip, got.reply_dest_ip);
                check_field("lookup_hit", exp_r.lookup_hit, got.lookup_hit);
                check_field("lookup_mac", exp_r.lookup_mac, got.lookup_mac);
                check_field("expired_count", exp_r.expired_count, got.expired_count);
                check_field("pad", '0, got.pad);
            end
        end
    end

    // Receiver stalls: the ready pattern is switched at random among four modes
    int stall_mode = 0;
    int stall_cnt  = 0;
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (stall_cnt % 8 == 0);
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    initial begin
        #40ms;
        $display("arp_cache_responder_core verification failed");
        $finish;
    end

    initial begin
        own_ip_q    = 32'd0;
        lifetime_q  = LIFETIME_RST;
        cache_count = 0;
        for (int i = 0; i < 48; i++) ip_pool[i] = $urandom;
        ip_pool[0] = 32'd0;
        ip_pool[1] = '1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_header_checks();
        test_deadline_wrap();
        test_random_traffic($urandom, 48'({$urandom, $urandom}), 32'd500, 64'd0, 60, 450);
        test_random_traffic('1, '1, '1, 64'hFFFF_FFFF_FFFF_F000, 400, 400);
        test_random_traffic(32'd0, 48'd0, 32'd0, {$urandom, $urandom}, 3, 300);
        test_random_traffic($urandom, 48'({$urandom, $urandom}), $urandom_range(1, 5000),
                            {$urandom, $urandom}, 300, 700);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("arp_cache_responder_core verification clean");
        else
            $display("arp_cache_responder_core verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/arpc_pkg.sv
rtl/core/arpc_front.sv
rtl/core/arpc_queue.sv
rtl/core/arpc_back.sv
rtl/core/arp_cache_responder_core.sv
verif/arp_cache_responder_core_test.sv
